// File: hdl/assert_macros.svh
// Assertion macros used by the checker file idl_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a implies b in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: a implies b");

// Check that a implies b in the next cycle.
`define ASSERT_NEXT(label, clk, a, b) \
   label: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("assertion failed: a implies b next cycle");

`endif

// File: hdl/idl_pkg.sv
`default_nettype none
package idl_pkg;
   localparam int DEPTH      = 16;
   localparam int ENTRY_BITS = 64;
   localparam int CMD_W      = 3;
   localparam int POS_W      = 5;
   localparam int DATA_W     = 64;
   localparam int COUNT_W    = 5;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int CMP_W      = (POS_W > CNT_W) ? POS_W : CNT_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ        = 3'd0,
      CMD_APPEND      = 3'd1,
      CMD_REMOVE_TAIL = 3'd2,
      CMD_INSERT      = 3'd3,
      CMD_REMOVE_AT   = 3'd4
   } cmd_type;

   typedef struct packed {
      logic                  shift_up;
      logic                  shift_down;
      logic [IDX_W-1:0]      at;
      logic [ENTRY_BITS-1:0] word;
   } ctl_type;
endpackage
`default_nettype wire

// File: hdl/idl_req_if.sv
`default_nettype none
interface idl_req_if import idl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [POS_W-1:0]  position;
   logic [DATA_W-1:0] entry_data;

   modport source (output valid, command, position, entry_data, input ready);
   modport sink   (input valid, command, position, entry_data, output ready);
endinterface
`default_nettype wire

// File: hdl/idl_rsp_if.sv
`default_nettype none
interface idl_rsp_if import idl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               found;
   logic [DATA_W-1:0]  entry_out;
   logic               accepted;
   logic [COUNT_W-1:0] count;

   modport source (output valid, found, entry_out, accepted, count, input ready);
   modport sink   (input valid, found, entry_out, accepted, count, output ready);
endinterface
`default_nettype wire

// File: hdl/idl_cell.sv
`default_nettype none
module idl_cell import idl_pkg::*; (
   input  wire                   clock,
   input  wire ctl_type          ctl,
   input  wire [IDX_W-1:0]       cell_index,
   input  wire [ENTRY_BITS-1:0]  left_word,
   input  wire [ENTRY_BITS-1:0]  right_word,
   output logic [ENTRY_BITS-1:0] word
);
   logic [ENTRY_BITS-1:0] word_ff;
   logic [ENTRY_BITS-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.shift_up) begin
         if (cell_index == ctl.at) begin
            word_in = ctl.word;
         end else if (cell_index > ctl.at) begin
            word_in = left_word;
         end
      end else if (ctl.shift_down) begin
         if (cell_index >= ctl.at) begin
            word_in = right_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
endmodule
`default_nettype wire

// File: hdl/indexed_insert_delete_list.sv
// Result: the result word of a command is registered at the clock edge that accepts it.
// Throughput: one command per cycle unless a held result stalls ready; every cell
// shifts in parallel, so the occupancy register is the only dependency between commands.
// Reset: synchronous, active high; clears the count and the result valid.
// Entry cells are not reset; only entries below the count are ever read.
`default_nettype none
module indexed_insert_delete_list import idl_pkg::*; (
   input wire      clock,
   input wire      reset,
   idl_req_if.sink   req_ch,
   idl_rsp_if.source rsp_ch
);
   logic [ENTRY_BITS-1:0] cell_word [DEPTH];
   ctl_type               ctl;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]      occ_ff, occ_in;
   logic                  found_ff, found_in;
   logic [ENTRY_BITS-1:0] word_ff, word_in;
   logic                  accepted_ff, accepted_in;

   logic                  accept;
   logic [CMP_W-1:0]      pos_ext, occ_ext;
   logic                  in_range, is_full, is_empty;
   logic [IDX_W-1:0]      sel_idx;
   logic [ENTRY_BITS-1:0] sel_word;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign pos_ext  = CMP_W'(req_ch.position);
   assign occ_ext  = CMP_W'(occ_ff);
   assign in_range = pos_ext < occ_ext;
   assign is_full  = occ_ff >= CNT_W'(DEPTH);
   assign is_empty = occ_ff == '0;
   assign sel_word = cell_word[sel_idx];

   always_comb begin
      found_in    = 1'b0;
      accepted_in = 1'b1;
      occ_in      = occ_ff;
      sel_idx     = IDX_W'(req_ch.position);
      ctl         = '0;
      ctl.word    = ENTRY_BITS'(req_ch.entry_data);
      case (cmd_type'(req_ch.command))
         CMD_READ: begin
            found_in = in_range;
         end
         CMD_APPEND: begin
            if (is_full) begin
               accepted_in = 1'b0;
            end else begin
               ctl.shift_up = accept;
               ctl.at       = IDX_W'(occ_ff);
               occ_in       = occ_ff + 1'b1;
            end
         end
         CMD_REMOVE_TAIL: begin
            sel_idx = IDX_W'(occ_ff - 1'b1);
            if (!is_empty) begin
               found_in       = 1'b1;
               ctl.shift_down = accept;
               ctl.at         = sel_idx;
               occ_in         = occ_ff - 1'b1;
            end
         end
         CMD_INSERT: begin
            if (is_full) begin
               accepted_in = 1'b0;
            end else begin
               ctl.shift_up = accept;
               ctl.at       = in_range ? IDX_W'(req_ch.position) : IDX_W'(occ_ff);
               occ_in       = occ_ff + 1'b1;
            end
         end
         CMD_REMOVE_AT: begin
            if (in_range) begin
               found_in       = 1'b1;
               ctl.shift_down = accept;
               ctl.at         = IDX_W'(req_ch.position);
               occ_in         = occ_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
      word_in = found_in ? sel_word : '0;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ENTRY_BITS-1:0] left_word, right_word;
      if (i == 0) begin : g_head
         assign left_word = ctl.word;
      end else begin : g_left
         assign left_word = cell_word[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_word = cell_word[i];
      end else begin : g_right
         assign right_word = cell_word[i+1];
      end
      idl_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .cell_index (IDX_W'(i)),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (cell_word[i])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            occ_ff <= occ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         found_ff    <= found_in;
         word_ff     <= word_in;
         accepted_ff <= accepted_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.found     = found_ff;
   assign rsp_ch.entry_out = DATA_W'(word_ff);
   assign rsp_ch.accepted  = accepted_ff;
   assign rsp_ch.count     = COUNT_W'(occ_ff);
endmodule
`default_nettype wire

// File: hdl/idl_checker.sv
`default_nettype none
`include "assert_macros.svh"
module idl_checker import idl_pkg::*; (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_ready,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input wire               rsp_found,
   input wire [DATA_W-1:0]  rsp_entry_out,
   input wire               rsp_accepted,
   input wire [COUNT_W-1:0] rsp_count
);
   `ASSERT_IMPLY(a_rsp_hold, clock, reset, $past(rsp_valid && !rsp_ready) && !$past(reset), rsp_valid)
   `ASSERT_IMPLY(a_count_max, clock, reset, rsp_valid, rsp_count <= COUNT_W'(DEPTH))
   `ASSERT_IMPLY(a_found_ok, clock, reset, rsp_valid && rsp_found, rsp_accepted)
   `ASSERT_IMPLY(a_zero_miss, clock, reset, rsp_valid && !rsp_found, rsp_entry_out == '0)
   `ASSERT_NEXT(a_reset_idle, clock, reset, !rsp_valid && (req_ready || !req_valid))
endmodule

bind indexed_insert_delete_list idl_checker u_idl_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_found     (rsp_ch.found),
   .rsp_entry_out (rsp_ch.entry_out),
   .rsp_accepted  (rsp_ch.accepted),
   .rsp_count     (rsp_ch.count)
);
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
   import idl_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic               found;
      logic [DATA_W-1:0]  entry_out;
      logic               accepted;
      logic [COUNT_W-1:0] count;
   } list_reply_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   idl_req_if req_ch ();
   idl_rsp_if rsp_ch ();

   indexed_insert_delete_list u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [ENTRY_BITS-1:0] list_words [DEPTH];
   int unsigned           list_count = 0;
   list_reply_t           pending_replies [$];

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int sent_items     = 0;
   int checked_words  = 0;
   int found_words    = 0;
   int rejected_words = 0;
   int full_hits      = 0;
   int mismatch_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.command    = '0;
      req_ch.position   = '0;
      req_ch.entry_data = '0;
      rsp_ch.ready      = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   function automatic void open_slot(input int unsigned at, input logic [DATA_W-1:0] data);
      for (int i = list_count; i > at; i--) list_words[i] = list_words[i-1];
      list_words[at] = data[ENTRY_BITS-1:0];
      list_count++;
   endfunction

   function automatic logic [ENTRY_BITS-1:0] close_slot(input int unsigned at);
      logic [ENTRY_BITS-1:0] word;
      word = list_words[at];
      for (int i = at; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
      list_count--;
      return word;
   endfunction

   function automatic list_reply_t apply_list_command(input logic [CMD_W-1:0] cmd,
                                                      input logic [POS_W-1:0] pos,
                                                      input logic [DATA_W-1:0] data);
      list_reply_t r;
      r = '0;
      r.accepted = 1'b1;
      case (cmd)
         CMD_READ: begin
            if (pos < list_count) begin
               r.found     = 1'b1;
               r.entry_out = DATA_W'(list_words[pos]);
            end
         end
         CMD_APPEND: begin
            if (list_count >= DEPTH) r.accepted = 1'b0;
            else open_slot(list_count, data);
         end
         CMD_REMOVE_TAIL: begin
            if (list_count > 0) begin
               r.found     = 1'b1;
               r.entry_out = DATA_W'(close_slot(list_count - 1));
            end
         end
         CMD_INSERT: begin
            if (list_count >= DEPTH) r.accepted = 1'b0;
            else open_slot((pos < list_count) ? pos : list_count, data);
         end
         CMD_REMOVE_AT: begin
            if (pos < list_count) begin
               r.found     = 1'b1;
               r.entry_out = DATA_W'(close_slot(pos));
            end
         end
         default: ;
      endcase
      r.count = COUNT_W'(list_count);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                  input logic [DATA_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("mismatch on %s at word %0d: expected %h, got %h",
                  what, checked_words, want, got);
   endtask

   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                               input logic [DATA_W-1:0] data);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.position   <= pos;
      req_ch.entry_data <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (list_count == DEPTH) full_hits++;
      pending_replies.push_back(apply_list_command(cmd, pos, data));
      sent_items++;
   endtask

   always @(posedge clock) begin : check_replies
      list_reply_t want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_replies.size() == 0) begin
            report_mismatch("unexpected word", '0, rsp_ch.entry_out);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_ch.found !== want.found)
               report_mismatch("found", DATA_W'(want.found), DATA_W'(rsp_ch.found));
            if (rsp_ch.entry_out !== want.entry_out)
               report_mismatch("entry_out", want.entry_out, rsp_ch.entry_out);
            if (rsp_ch.accepted !== want.accepted)
               report_mismatch("accepted", DATA_W'(want.accepted), DATA_W'(rsp_ch.accepted));
            if (rsp_ch.count !== want.count)
               report_mismatch("count", DATA_W'(want.count), DATA_W'(rsp_ch.count));
            if (want.found) found_words++;
            if (!want.accepted) rejected_words++;
         end
         checked_words++;
      end
   end

   task automatic test_empty_list();
      send_command(CMD_READ, 5'd31, '0);
      send_command(CMD_REMOVE_TAIL, '0, '0);
      send_command(CMD_INSERT, 5'd9, '1);
      send_command(CMD_REMOVE_AT, '0, '0);
   endtask

   task automatic test_full_list();
      for (int i = 0; i < DEPTH - 2; i++)
         send_command(CMD_APPEND, '0, {32'(i) ^ 32'hA5A5_0F0F, ~32'(i)});
      send_command(CMD_INSERT, '0, '0);
      send_command(CMD_INSERT, 5'd20, 64'h8000_0000_0000_0001);
      send_command(CMD_APPEND, '0, 64'hDEAD_BEEF_0123_4567);
      send_command(CMD_INSERT, 5'd3, 64'h0123_4567_DEAD_BEEF);
      send_command(CMD_REMOVE_AT, 5'd16, '0);
      send_command(CMD_REMOVE_AT, 5'd7, '0);
   endtask

   task automatic test_spare_codes();
      send_command(CMD_SPARE_5, 5'd1, '1);
      send_command(CMD_SPARE_6, 5'd2, '1);
      send_command(CMD_SPARE_7, 5'd31, '1);
   endtask

   task automatic test_random_traffic(input int n);
      logic [CMD_W-1:0]  cmd;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] data;
      int                pick;
      int                grow_pct;
      for (int i = 0; i < n; i++) begin
         grow_pct = ((i / 48) % 2 == 0) ? 70 : 30;
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            cmd = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
         end else if (pick < 20) begin
            cmd = CMD_READ;
         end else if ($urandom_range(0, 99) < grow_pct) begin
            cmd = $urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT;
         end else begin
            cmd = $urandom_range(0, 1) ? CMD_REMOVE_TAIL : CMD_REMOVE_AT;
         end
         if ($urandom_range(0, 9) == 0) pos = 5'($urandom_range(0, 31));
         else pos = 5'($urandom_range(0, list_count));
         data = {$urandom, $urandom};
         send_command(cmd, pos, data);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 13;
      recv_idle_pct = 74;
      test_empty_list();
      test_full_list();
      test_spare_codes();
      test_random_traffic(330);

      send_idle_pct = 74;
      recv_idle_pct = 13;
      test_random_traffic(330);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(340);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("run covered %0d commands and %0d result words over three idle mixes",
               sent_items, checked_words);
      $display("entries returned %0d, full-list rejects %0d, commands at full %0d",
               found_words, rejected_words, full_hits);
      if (mismatch_count == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end
endmodule

// File: indexed_insert_delete_list.f
+incdir+hdl
hdl/idl_pkg.sv
hdl/idl_req_if.sv
hdl/idl_rsp_if.sv
hdl/idl_cell.sv
hdl/indexed_insert_delete_list.sv
hdl/idl_checker.sv
tb/sv/tb.sv
